/* rtl/blse_pkg.sv */
// Shared types and constants for the bounded list stack engine.
// No dependencies; used by blse_mem and bounded_list_stack_engine_core.
package blse_pkg;

  // List geometry
  localparam int unsigned Depth  = 16;
  localparam int unsigned AddrW  = $clog2(Depth);
  localparam int unsigned CntW   = $clog2(Depth + 1);
  localparam int unsigned DataW  = 32;
  localparam int unsigned LevelW = 5;

  // Operation codes on func_i
  typedef enum logic [1:0] {
    FUNC_APPEND     = 2'd0,
    FUNC_POP_TAIL   = 2'd1,
    FUNC_POP_HEAD   = 2'd2,
    FUNC_REMOVE_VAL = 2'd3
  } func_e;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_EMPTY     = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } status_e;

  // Sequencer states
  typedef enum logic [3:0] {
    SEQ_IDLE,
    SEQ_TAKE_RD,
    SEQ_TAKE_CAP,
    SEQ_FIND_RD,
    SEQ_FIND_CMP,
    SEQ_SHIFT_RD,
    SEQ_SHIFT_WR,
    SEQ_HEAD_RD,
    SEQ_HEAD_CAP,
    SEQ_TAIL_CAP,
    SEQ_DONE
  } seq_state_e;

  // One port request to the entry memory
  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    logic [DataW-1:0] wdata;
    logic [AddrW-1:0] raddr;
  } mem_req_t;

endpackage

/* rtl/bounded_list_stack_engine_core.sv */
// Top level of the bounded list stack engine: sequencer, compare unit, result regs.
// Depends on blse_pkg and blse_mem.
//
//  channel   direction  handshake             payload
//  command   in         start / busy          func_i, value_i
//  result    out        valid_o (1-cycle)     status_o, removed_value_o, fill_level_o,
//                                             is_empty_o, front_value_o, top_value_o
//
// Steps, start beat to result beat: an append (also a refused one) or a removal on an
// empty list goes straight to the head and tail read-back; a removal first reads its
// entry (a value removal compares one entry at a time from the head) and closes any gap
// with a read and a write per entry moved. An empty list skips the read-back.
// Reset clears the fill count and the sequencer; entries need no clearing.
// busy stays high through the result beat; the receiver cannot stall it.
module bounded_list_stack_engine_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  func_i,
  input  logic signed [31:0]          value_i,
  output logic                        valid_o,
  output logic [1:0]                  status_o,
  output logic signed [31:0]          removed_value_o,
  output logic [4:0]                  fill_level_o,
  output logic                        is_empty_o,
  output logic signed [31:0]          front_value_o,
  output logic signed [31:0]          top_value_o
);

  localparam int unsigned AddrW = blse_pkg::AddrW;
  localparam int unsigned CntW  = blse_pkg::CntW;
  localparam int unsigned DataW = blse_pkg::DataW;

  blse_pkg::seq_state_e state_q, state_d;
  blse_pkg::status_e    status_q, status_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [AddrW-1:0]     idx_q, idx_d;
  logic [DataW-1:0]     value_q, value_d;
  logic [DataW-1:0]     removed_q, removed_d;
  logic [DataW-1:0]     front_q, front_d;
  logic [DataW-1:0]     top_q, top_d;

  blse_pkg::mem_req_t   mem_req;
  logic [DataW-1:0]     rdata;

  logic [CntW-1:0]      idx_nxt_c;
  logic [CntW-1:0]      idx_nxt2_c;
  logic                 more_c;
  logic                 full_c;
  logic                 empty_c;
  logic                 match_c;

  blse_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

  // Shared index arithmetic and the single compare unit
  assign idx_nxt_c  = CntW'(idx_q) + CntW'(1);
  assign idx_nxt2_c = CntW'(idx_q) + CntW'(2);
  assign more_c     = (idx_nxt_c < cnt_q);
  assign full_c     = (cnt_q == CntW'(blse_pkg::Depth));
  assign empty_c    = (cnt_q == '0);
  assign match_c    = (rdata == value_q);

  // State and payload registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= blse_pkg::SEQ_IDLE;
      cnt_q    <= '0;
      status_q <= blse_pkg::STAT_OK;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    value_q   <= value_d;
    removed_q <= removed_d;
    front_q   <= front_d;
    top_q     <= top_d;
  end

  // Sequencer: next state, datapath updates, memory requests
  always_comb begin
    state_d       = state_q;
    status_d      = status_q;
    cnt_d         = cnt_q;
    idx_d         = idx_q;
    value_d       = value_q;
    removed_d     = removed_q;
    front_d       = front_q;
    top_d         = top_q;
    mem_req.we    = 1'b0;
    mem_req.waddr = idx_q;
    mem_req.wdata = rdata;
    mem_req.raddr = idx_q;

    unique case (state_q)
      blse_pkg::SEQ_IDLE: begin
        if (start) begin
          value_d   = value_i;
          removed_d = '0;
          status_d  = blse_pkg::STAT_OK;
          state_d   = blse_pkg::SEQ_HEAD_RD;
          if (blse_pkg::func_e'(func_i) == blse_pkg::FUNC_APPEND) begin
            if (full_c) begin
              status_d = blse_pkg::STAT_FULL;
            end else begin
              mem_req.we    = 1'b1;
              mem_req.waddr = cnt_q[AddrW-1:0];
              mem_req.wdata = value_i;
              cnt_d         = cnt_q + CntW'(1);
            end
          end else if (empty_c) begin
            status_d = blse_pkg::STAT_EMPTY;
          end else begin
            unique case (blse_pkg::func_e'(func_i))
              blse_pkg::FUNC_POP_TAIL: begin
                idx_d   = AddrW'(cnt_q - CntW'(1));
                state_d = blse_pkg::SEQ_TAKE_RD;
              end
              blse_pkg::FUNC_POP_HEAD: begin
                idx_d   = '0;
                state_d = blse_pkg::SEQ_TAKE_RD;
              end
              default: begin
                idx_d   = '0;
                state_d = blse_pkg::SEQ_FIND_RD;
              end
            endcase
          end
        end
      end

      blse_pkg::SEQ_TAKE_RD: begin
        state_d = blse_pkg::SEQ_TAKE_CAP;
      end

      blse_pkg::SEQ_TAKE_CAP: begin
        removed_d = rdata;
        if (more_c) begin
          state_d = blse_pkg::SEQ_SHIFT_RD;
        end else begin
          cnt_d   = cnt_q - CntW'(1);
          state_d = blse_pkg::SEQ_HEAD_RD;
        end
      end

      blse_pkg::SEQ_FIND_RD: begin
        state_d = blse_pkg::SEQ_FIND_CMP;
      end

      // one compare per entry, head first
      blse_pkg::SEQ_FIND_CMP: begin
        if (match_c) begin
          removed_d = rdata;
          if (more_c) begin
            state_d = blse_pkg::SEQ_SHIFT_RD;
          end else begin
            cnt_d   = cnt_q - CntW'(1);
            state_d = blse_pkg::SEQ_HEAD_RD;
          end
        end else if (more_c) begin
          idx_d   = idx_nxt_c[AddrW-1:0];
          state_d = blse_pkg::SEQ_FIND_RD;
        end else begin
          status_d = blse_pkg::STAT_NOT_FOUND;
          state_d  = blse_pkg::SEQ_HEAD_RD;
        end
      end

      // close the gap: entry idx+1 moves down to idx
      blse_pkg::SEQ_SHIFT_RD: begin
        mem_req.raddr = idx_nxt_c[AddrW-1:0];
        state_d       = blse_pkg::SEQ_SHIFT_WR;
      end

      blse_pkg::SEQ_SHIFT_WR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = idx_q;
        mem_req.wdata = rdata;
        idx_d         = idx_nxt_c[AddrW-1:0];
        if (idx_nxt2_c < cnt_q) begin
          state_d = blse_pkg::SEQ_SHIFT_RD;
        end else begin
          cnt_d   = cnt_q - CntW'(1);
          state_d = blse_pkg::SEQ_HEAD_RD;
        end
      end

      // fetch head and tail for the result beat
      blse_pkg::SEQ_HEAD_RD: begin
        mem_req.raddr = '0;
        if (empty_c) begin
          front_d = '0;
          top_d   = '0;
          state_d = blse_pkg::SEQ_DONE;
        end else begin
          state_d = blse_pkg::SEQ_HEAD_CAP;
        end
      end

      blse_pkg::SEQ_HEAD_CAP: begin
        front_d       = rdata;
        mem_req.raddr = AddrW'(cnt_q - CntW'(1));
        state_d       = blse_pkg::SEQ_TAIL_CAP;
      end

      blse_pkg::SEQ_TAIL_CAP: begin
        top_d   = rdata;
        state_d = blse_pkg::SEQ_DONE;
      end

      blse_pkg::SEQ_DONE: begin
        state_d = blse_pkg::SEQ_IDLE;
      end

      default: begin
        state_d = blse_pkg::SEQ_IDLE;
      end
    endcase
  end

  // Result beat
  assign busy            = (state_q != blse_pkg::SEQ_IDLE);
  assign valid_o         = (state_q == blse_pkg::SEQ_DONE);
  assign status_o        = status_q;
  assign removed_value_o = removed_q;
  assign fill_level_o    = blse_pkg::LevelW'(cnt_q);
  assign is_empty_o      = empty_c;
  assign front_value_o   = front_q;
  assign top_value_o     = top_q;

endmodule

/* rtl/blse_mem.sv */
// Entry memory of the list: one write and one registered read per cycle.
// Depends on blse_pkg for geometry and the request struct.
module blse_mem (
  input  logic                     clk_i,
  input  blse_pkg::mem_req_t       req_i,
  output logic [blse_pkg::DataW-1:0] rdata_o
);

  logic [blse_pkg::DataW-1:0] mem_q [blse_pkg::Depth];
  logic [blse_pkg::DataW-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem_q[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule
